/* rtl/lsrt_pkg.sv */
`timescale 1ns / 1ps
package lsrt_pkg;

  localparam int SLOTS      = 8;
  localparam int PAGE_SHIFT = 13;
  localparam int PAGE_W     = 36;
  localparam int LIMIT_W    = 48;
  localparam int RZ_W       = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam int SLOT_AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // Leftover byte size and the release threshold, compared at a common width.
  localparam int BYTES_W    = PAGE_W + PAGE_SHIFT;
  localparam int THR_W      = LIMIT_W + 1;
  localparam int CMP_W      = (BYTES_W > THR_W) ? BYTES_W : THR_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(262144);
  localparam logic [RZ_W-1:0]    RZ_RESET    = RZ_W'(16);

  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REDZONE     = CFG_IDX_W'(1);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [SLOT_AW-1:0] slot_idx_t;

  typedef struct packed {
    logic  command;
    page_t span_start;
    page_t span_length;
    page_t request_pages;
  } in_word_t;

  typedef struct packed {
    logic  ok;
    page_t granted_start;
    page_t granted_length;
    logic  dropped_valid;
    page_t dropped_start;
    page_t dropped_length;
  } out_word_t;

  typedef struct packed {
    page_t start;
    page_t length;
  } span_t;

  typedef struct packed {
    logic      clear;
    logic      cmp_vld;
    logic      is_alloc;
    logic      slot_vld;
    slot_idx_t cmp_idx;
  } scan_ctl_t;

  typedef struct packed {
    logic      found;
    slot_idx_t idx;
    page_t     start;
    page_t     length;
  } scan_best_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_SPLIT
  } state_t;

endpackage

/* rtl/lsrt_span_ram.sv */
`timescale 1ns / 1ps
module lsrt_span_ram (
  input  logic               clk,
  input  logic               we,
  input  lsrt_pkg::slot_idx_t waddr,
  input  lsrt_pkg::span_t    wdata,
  input  lsrt_pkg::slot_idx_t raddr,
  output lsrt_pkg::span_t    rdata
);

  lsrt_pkg::span_t mem [lsrt_pkg::SLOTS];
  lsrt_pkg::span_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lsrt_scan.sv */
`timescale 1ns / 1ps
module lsrt_scan (
  input  logic                  clk,
  input  lsrt_pkg::scan_ctl_t   ctl,
  input  lsrt_pkg::span_t       rdata,
  input  lsrt_pkg::page_t       request,
  output lsrt_pkg::scan_best_t  best
);

  lsrt_pkg::scan_best_t best_r, best_nxt;
  logic take;

  // Add looks for the first smallest span, allocate for the first largest
  // valid span that covers the request; strict compares keep the first one.
  always_comb begin
    if (ctl.is_alloc) begin
      take = ctl.slot_vld && (rdata.length >= request) &&
             (!best_r.found || (rdata.length > best_r.length));
    end else begin
      take = !best_r.found || (rdata.length < best_r.length);
    end
    best_nxt = best_r;
    if (ctl.clear) begin
      best_nxt.found = 1'b0;
    end else if (ctl.cmp_vld && take) begin
      best_nxt.found  = 1'b1;
      best_nxt.idx    = ctl.cmp_idx;
      best_nxt.start  = rdata.start;
      best_nxt.length = rdata.length;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign best = best_r;

endmodule

/* rtl/large_span_reuse_table.sv */
`timescale 1ns / 1ps
// An add into a table with an empty slot, or a zero request, gives its
// result in the cycle after acceptance. Any other command scans the slot
// memory one entry per cycle, then DRAIN and DECIDE, and SPLIT for a split.
// One command at a time: busy is high while a scan is in progress and falls
// as its result word is issued; the next command can be accepted then.
// Reset (synchronous, rst_n low) empties the table and restores the register
// defaults; the result strobe cannot be stalled by the receiver.
module large_span_reuse_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  lsrt_pkg::in_word_t               in_item,
  output logic                             out_valid,
  output lsrt_pkg::out_word_t              out_item,
  input  logic                             cfg_we,
  input  logic [lsrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsrt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam lsrt_pkg::slot_idx_t LAST = lsrt_pkg::SLOT_AW'(lsrt_pkg::SLOTS - 1);

  lsrt_pkg::state_t   state_r, state_nxt;
  lsrt_pkg::slot_idx_t idx_r, idx_nxt;
  lsrt_pkg::slot_idx_t cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [lsrt_pkg::SLOTS-1:0] valid_r, valid_nxt;
  lsrt_pkg::in_word_t cmd_r, cmd_nxt;
  logic [lsrt_pkg::LIMIT_W-1:0] limit_r;
  logic [lsrt_pkg::RZ_W-1:0]    rz_r;
  lsrt_pkg::page_t    rest_start_r, rest_start_nxt;
  lsrt_pkg::page_t    rest_len_r, rest_len_nxt;
  logic [lsrt_pkg::THR_W-1:0] thresh_r, thresh_nxt;
  logic               out_valid_r, out_valid_nxt;
  lsrt_pkg::out_word_t out_r, out_nxt;

  logic               ram_we;
  lsrt_pkg::slot_idx_t ram_waddr;
  lsrt_pkg::span_t    ram_wdata;
  lsrt_pkg::span_t    ram_rdata;
  lsrt_pkg::scan_ctl_t scan_ctl;
  lsrt_pkg::scan_best_t best;
  logic               scan_clear;
  logic               has_empty;
  lsrt_pkg::slot_idx_t first_empty;
  logic [lsrt_pkg::CMP_W-1:0] rest_bytes;
  logic               accept;

  lsrt_span_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign scan_ctl.clear    = scan_clear;
  assign scan_ctl.cmp_vld  = cmp_vld_r;
  assign scan_ctl.is_alloc = (cmd_r.command == lsrt_pkg::CMD_ALLOC);
  assign scan_ctl.slot_vld = valid_r[cmp_idx_r];
  assign scan_ctl.cmp_idx  = cmp_idx_r;

  lsrt_scan u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .rdata   (ram_rdata),
    .request (cmd_r.request_pages),
    .best    (best)
  );

  always_comb begin
    has_empty   = ~&valid_r;
    first_empty = '0;
    for (int i = lsrt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        first_empty = lsrt_pkg::SLOT_AW'(i);
      end
    end
  end

  assign rest_bytes = lsrt_pkg::CMP_W'(rest_len_r) << lsrt_pkg::PAGE_SHIFT;
  assign accept     = start && (state_r == lsrt_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cmp_vld_nxt    = (state_r == lsrt_pkg::ST_SCAN);
    cmp_idx_nxt    = idx_r;
    valid_nxt      = valid_r;
    cmd_nxt        = cmd_r;
    rest_start_nxt = rest_start_r;
    rest_len_nxt   = rest_len_r;
    thresh_nxt     = thresh_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = best.idx;
    ram_wdata      = '0;
    scan_clear     = 1'b0;

    case (state_r)
      lsrt_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_item;
          if (in_item.command == lsrt_pkg::CMD_ADD && has_empty) begin
            ram_we                 = 1'b1;
            ram_waddr              = first_empty;
            ram_wdata.start        = in_item.span_start;
            ram_wdata.length       = in_item.span_length;
            valid_nxt[first_empty] = 1'b1;
            out_valid_nxt          = 1'b1;
            out_nxt                = '0;
            out_nxt.ok             = 1'b1;
          end else if (in_item.command == lsrt_pkg::CMD_ALLOC &&
                       in_item.request_pages == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end else begin
            scan_clear = 1'b1;
            idx_nxt    = '0;
            state_nxt  = lsrt_pkg::ST_SCAN;
          end
        end
      end
      lsrt_pkg::ST_SCAN: begin
        if (idx_r == LAST) begin
          state_nxt = lsrt_pkg::ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      lsrt_pkg::ST_DRAIN: begin
        // The last entry is compared in this cycle.
        state_nxt = lsrt_pkg::ST_DECIDE;
      end
      lsrt_pkg::ST_DECIDE: begin
        state_nxt     = lsrt_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        if (cmd_r.command == lsrt_pkg::CMD_ADD) begin
          if (cmd_r.span_length > best.length) begin
            ram_we                 = 1'b1;
            ram_wdata.start        = cmd_r.span_start;
            ram_wdata.length       = cmd_r.span_length;
            out_nxt.ok             = 1'b1;
            out_nxt.dropped_valid  = 1'b1;
            out_nxt.dropped_start  = best.start;
            out_nxt.dropped_length = best.length;
          end
        end else if (best.found) begin
          out_nxt.ok             = 1'b1;
          out_nxt.granted_start  = best.start;
          out_nxt.granted_length = cmd_r.request_pages;
          if (best.length == cmd_r.request_pages) begin
            valid_nxt[best.idx] = 1'b0;
          end else begin
            // Hold the result back to size up the leftover in ST_SPLIT.
            out_valid_nxt  = 1'b0;
            state_nxt      = lsrt_pkg::ST_SPLIT;
            rest_start_nxt = best.start + cmd_r.request_pages;
            rest_len_nxt   = best.length - cmd_r.request_pages;
            thresh_nxt     = lsrt_pkg::THR_W'(limit_r) +
                             (lsrt_pkg::THR_W'(rz_r) << 1);
          end
        end
      end
      lsrt_pkg::ST_SPLIT: begin
        state_nxt     = lsrt_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        // Byte size minus two redzones at or below the limit, or negative.
        if (rest_bytes <= lsrt_pkg::CMP_W'(thresh_r)) begin
          valid_nxt[best.idx]    = 1'b0;
          out_nxt.dropped_valid  = 1'b1;
          out_nxt.dropped_start  = rest_start_r;
          out_nxt.dropped_length = rest_len_r;
        end else begin
          ram_we           = 1'b1;
          ram_wdata.start  = rest_start_r;
          ram_wdata.length = rest_len_r;
        end
      end
      default: begin
        state_nxt = lsrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsrt_pkg::ST_IDLE;
      valid_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    cmd_r        <= cmd_nxt;
    rest_start_r <= rest_start_nxt;
    rest_len_r   <= rest_len_nxt;
    thresh_r     <= thresh_nxt;
    out_r        <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lsrt_pkg::LIMIT_RESET;
      rz_r    <= lsrt_pkg::RZ_RESET;
    end else if (cfg_we) begin
      if (cfg_index == lsrt_pkg::CFG_SMALL_LIMIT) begin
        limit_r <= cfg_wdata[lsrt_pkg::LIMIT_W-1:0];
      end
      if (cfg_index == lsrt_pkg::CFG_REDZONE) begin
        rz_r <= cfg_wdata[lsrt_pkg::RZ_W-1:0];
      end
    end
  end

  assign busy      = (state_r != lsrt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(accept))
    else $error("result word without a command in progress");

  a_grant_matches_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.ok && (cmd_r.command == lsrt_pkg::CMD_ALLOC) |->
      out_item.granted_length == cmd_r.request_pages)
    else $error("granted length differs from the request");

  a_drop_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.dropped_valid |-> out_item.ok)
    else $error("span dropped by a failed command");

  a_scan_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsrt_pkg::ST_SCAN) && (idx_r != LAST) |=> idx_r == $past(idx_r) + 1'b1)
    else $error("scan skipped a slot");
`endif

endmodule

/* bench/tb_large_span_reuse_table.sv */
`timescale 1ns / 1ps
module tb_large_span_reuse_table;

  localparam int SETTLE_CYCLES = lsrt_pkg::SLOTS + 8;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  lsrt_pkg::in_word_t              in_item = '0;
  logic                            out_valid;
  lsrt_pkg::out_word_t             out_item;
  logic                            cfg_we = 1'b0;
  logic [lsrt_pkg::CFG_IDX_W-1:0]  cfg_index = lsrt_pkg::CFG_SMALL_LIMIT;
  logic [lsrt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the span table and its registers.
  logic                          span_live [lsrt_pkg::SLOTS];
  lsrt_pkg::page_t               span_base [lsrt_pkg::SLOTS];
  lsrt_pkg::page_t               span_pages [lsrt_pkg::SLOTS];
  logic [lsrt_pkg::LIMIT_W-1:0]  small_limit;
  logic [lsrt_pkg::RZ_W-1:0]     redzone;

  lsrt_pkg::out_word_t outcome_q [$];
  int                  mismatch_count = 0;
  bit                  quiet = 1'b0;

  large_span_reuse_table uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic lsrt_pkg::out_word_t predict_outcome(input lsrt_pkg::in_word_t w);
    lsrt_pkg::out_word_t r;
    int                  slot;
    lsrt_pkg::page_t     rest;
    logic [63:0]         bytes;
    logic [63:0]         twice_rz;
    r = '0;
    slot = -1;
    if (w.command == lsrt_pkg::CMD_ADD) begin
      for (int i = 0; i < lsrt_pkg::SLOTS; i++) begin
        if (slot < 0 && !span_live[i]) slot = i;
      end
      if (slot >= 0) begin
        span_live[slot] = 1'b1;
        span_base[slot] = w.span_start;
        span_pages[slot] = w.span_length;
        r.ok = 1'b1;
      end else begin
        // Table is full: the first shortest span is the eviction candidate.
        slot = 0;
        for (int i = 1; i < lsrt_pkg::SLOTS; i++) begin
          if (span_pages[i] < span_pages[slot]) slot = i;
        end
        if (w.span_length > span_pages[slot]) begin
          r.ok = 1'b1;
          r.dropped_valid = 1'b1;
          r.dropped_start = span_base[slot];
          r.dropped_length = span_pages[slot];
          span_base[slot] = w.span_start;
          span_pages[slot] = w.span_length;
        end
      end
    end else if (w.request_pages != '0) begin
      for (int i = 0; i < lsrt_pkg::SLOTS; i++) begin
        if (span_live[i] && span_pages[i] >= w.request_pages &&
            (slot < 0 || span_pages[i] > span_pages[slot])) slot = i;
      end
      if (slot >= 0) begin
        r.ok = 1'b1;
        r.granted_start = span_base[slot];
        r.granted_length = w.request_pages;
        if (span_pages[slot] == w.request_pages) begin
          span_live[slot] = 1'b0;
        end else begin
          rest = span_pages[slot] - w.request_pages;
          bytes = 64'(rest) << lsrt_pkg::PAGE_SHIFT;
          twice_rz = 64'(redzone) * 2;
          if (bytes < twice_rz || bytes - twice_rz <= 64'(small_limit)) begin
            span_live[slot] = 1'b0;
            r.dropped_valid = 1'b1;
            r.dropped_start = span_base[slot] + w.request_pages;
            r.dropped_length = rest;
          end else begin
            span_base[slot] = span_base[slot] + w.request_pages;
            span_pages[slot] = rest;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [35:0] got,
                                 input logic [35:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    lsrt_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected result word, ok", 36'(out_item.ok), '0);
      end else begin
        want = outcome_q.pop_front();
        if (out_item.ok !== want.ok)
          report_mismatch("ok", 36'(out_item.ok), 36'(want.ok));
        if (out_item.granted_start !== want.granted_start)
          report_mismatch("granted_start", out_item.granted_start, want.granted_start);
        if (out_item.granted_length !== want.granted_length)
          report_mismatch("granted_length", out_item.granted_length, want.granted_length);
        if (out_item.dropped_valid !== want.dropped_valid)
          report_mismatch("dropped_valid", 36'(out_item.dropped_valid),
                          36'(want.dropped_valid));
        if (out_item.dropped_start !== want.dropped_start)
          report_mismatch("dropped_start", out_item.dropped_start, want.dropped_start);
        if (out_item.dropped_length !== want.dropped_length)
          report_mismatch("dropped_length", out_item.dropped_length, want.dropped_length);
      end
    end
  end

  // Called at a clock edge. Leaves start high so that a following word can be
  // presented in the same step; drain_results lowers it.
  task automatic send_word(input lsrt_pkg::in_word_t w);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    outcome_q.push_back(predict_outcome(w));
  endtask

  task automatic send_add(input lsrt_pkg::page_t base, input lsrt_pkg::page_t pages);
    lsrt_pkg::in_word_t w;
    w = '0;
    w.command = lsrt_pkg::CMD_ADD;
    w.span_start = base;
    w.span_length = pages;
    send_word(w);
  endtask

  task automatic send_alloc(input lsrt_pkg::page_t pages);
    lsrt_pkg::in_word_t w;
    w = '0;
    w.command = lsrt_pkg::CMD_ALLOC;
    w.request_pages = pages;
    send_word(w);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lsrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lsrt_pkg::CFG_DATA_W-1:0] data);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lsrt_pkg::CFG_SMALL_LIMIT) small_limit = data[lsrt_pkg::LIMIT_W-1:0];
    else redzone = data[lsrt_pkg::RZ_W-1:0];
  endtask

  function automatic lsrt_pkg::page_t rand_page();
    return lsrt_pkg::page_t'({$urandom(), $urandom()});
  endfunction

  function automatic lsrt_pkg::page_t pick_pages();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return lsrt_pkg::page_t'($urandom_range(1, 48));
    else if (sel < 80) return lsrt_pkg::page_t'($urandom_range(0, 4096));
    else if (sel < 90) return rand_page();
    else if (sel < 95) return '0;
    else return '1;
  endfunction

  task automatic test_fill_and_evict();
    send_add('0, lsrt_pkg::page_t'(1));
    send_add('1, '1);
    send_add(lsrt_pkg::page_t'(5), '0);
    send_add(lsrt_pkg::page_t'(100), lsrt_pkg::page_t'(40));
    send_add(lsrt_pkg::page_t'(200), lsrt_pkg::page_t'(33));
    send_add(lsrt_pkg::page_t'(300), lsrt_pkg::page_t'(64));
    send_add(lsrt_pkg::page_t'(400), lsrt_pkg::page_t'(32));
    send_add(lsrt_pkg::page_t'(500), lsrt_pkg::page_t'(100));
    // Full table, and the new span is no longer than the shortest one.
    send_add(lsrt_pkg::page_t'(600), '0);
    send_add(lsrt_pkg::page_t'(700), lsrt_pkg::page_t'(2));
  endtask

  task automatic test_allocate_paths();
    send_alloc('0);
    send_alloc('1);
    send_alloc(lsrt_pkg::page_t'(1000));
    send_alloc(lsrt_pkg::page_t'(60));
    send_alloc(lsrt_pkg::page_t'(40));
    // The leftover start runs past the top page number and wraps.
    send_add(36'hF_FFFF_FFF0, lsrt_pkg::page_t'(100));
    send_alloc(lsrt_pkg::page_t'(50));
  endtask

  task automatic test_register_extremes();
    write_reg(lsrt_pkg::CFG_SMALL_LIMIT, '0);
    write_reg(lsrt_pkg::CFG_REDZONE, lsrt_pkg::CFG_DATA_W'(12'hFFF));
    send_alloc(lsrt_pkg::page_t'(1));
    send_add(lsrt_pkg::page_t'(900), lsrt_pkg::page_t'(2));
    write_reg(lsrt_pkg::CFG_SMALL_LIMIT, lsrt_pkg::CFG_DATA_W'(48'hFFFF_FFFF_FFFF));
    write_reg(lsrt_pkg::CFG_REDZONE, '0);
    send_alloc(lsrt_pkg::page_t'(1));
    send_alloc(lsrt_pkg::page_t'(1));
  endtask

  task automatic test_random_traffic(input logic [lsrt_pkg::LIMIT_W-1:0] limit,
                                     input logic [lsrt_pkg::RZ_W-1:0] rz,
                                     input int count);
    lsrt_pkg::in_word_t w;
    int                 pick;
    write_reg(lsrt_pkg::CFG_SMALL_LIMIT, lsrt_pkg::CFG_DATA_W'(limit));
    write_reg(lsrt_pkg::CFG_REDZONE, lsrt_pkg::CFG_DATA_W'(rz));
    for (int n = 0; n < count; n++) begin
      w.command = ($urandom_range(0, 1) == 0) ? lsrt_pkg::CMD_ADD : lsrt_pkg::CMD_ALLOC;
      w.span_start = ($urandom_range(0, 9) == 0) ?
                     lsrt_pkg::page_t'('1) - lsrt_pkg::page_t'($urandom_range(0, 64)) :
                     rand_page();
      w.span_length = pick_pages();
      w.request_pages = pick_pages();
      // Often ask for exactly the size of a cached span.
      pick = $urandom_range(0, lsrt_pkg::SLOTS * 3 - 1);
      if (pick < lsrt_pkg::SLOTS && span_live[pick]) w.request_pages = span_pages[pick];
      send_word(w);
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  initial begin
    for (int i = 0; i < lsrt_pkg::SLOTS; i++) begin
      span_live[i] = 1'b0;
      span_base[i] = '0;
      span_pages[i] = '0;
    end
    small_limit = lsrt_pkg::LIMIT_RESET;
    redzone = lsrt_pkg::RZ_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_and_evict();
    test_allocate_paths();
    test_register_extremes();
    test_random_traffic(lsrt_pkg::LIMIT_RESET, lsrt_pkg::RZ_RESET, 260);
    test_random_traffic('0, '0, 260);
    test_random_traffic('1, '1, 250);
    test_random_traffic(lsrt_pkg::LIMIT_W'($urandom_range(0, 64) * 8192 +
                                           $urandom_range(0, 8191)),
                        lsrt_pkg::RZ_W'($urandom()), 260);
    test_random_traffic(lsrt_pkg::LIMIT_W'({$urandom(), $urandom()}),
                        lsrt_pkg::RZ_W'($urandom()), 260);
    drain_results();
    quiet = 1'b1;
    test_random_traffic(lsrt_pkg::LIMIT_RESET, lsrt_pkg::RZ_RESET, 260);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[large_span_reuse_table] OK");
    end else begin
      $display("[large_span_reuse_table] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("[large_span_reuse_table] ERROR");
    $finish;
  end

endmodule

/* large_span_reuse_table.f */
rtl/lsrt_pkg.sv
rtl/lsrt_span_ram.sv
rtl/lsrt_scan.sv
rtl/large_span_reuse_table.sv
bench/tb_large_span_reuse_table.sv
